FILE: rtl/core/brc_pkg.sv
// Shared types and constants for the barometer raw compensation pipeline.
package brc_pkg;

  localparam int DIV_W   = 32;
  localparam int STAGES  = 18;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 48;

  typedef enum logic [CFG_IW-1:0] {
    CFG_A123 = 3'd0,
    CFG_A456 = 3'd1,
    CFG_B12  = 3'd2,
    CFG_MCMD = 3'd3,
    CFG_OSS  = 3'd4
  } cfg_idx_t;

  // Everything an item carries down the pipe; pa/pb/pc are reused scratch.
  typedef struct packed {
    logic               op;
    logic               err;
    logic               neg;
    logic [23:0]        up;
    logic signed [15:0] t;
    logic signed [31:0] x1;
    logic signed [31:0] b5;
    logic signed [31:0] b6;
    logic signed [31:0] sq;
    logic signed [31:0] b3;
    logic signed [31:0] x3;
    logic signed [31:0] p;
    logic signed [31:0] pa;
    logic signed [31:0] pb;
    logic signed [31:0] pc;
  } item_t;

endpackage

FILE: rtl/core/brc_if.sv
// Valid/ready channels for raw samples and compensated results.
interface brc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] raw_temperature;
  logic [23:0] raw_pressure;
  modport source (output valid, operation, raw_temperature, raw_pressure, input ready);
  modport sink   (input valid, operation, raw_temperature, raw_pressure, output ready);
endinterface

interface brc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_tenths;
  logic signed [31:0] pressure_pa;
  logic               divide_error;
  modport source (output valid, temperature_tenths, pressure_pa, divide_error, input ready);
  modport sink   (input valid, temperature_tenths, pressure_pa, divide_error, output ready);
endinterface

FILE: rtl/core/brc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module brc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  brc_pkg::item_t            in_item,
  input  logic [brc_pkg::DIV_W-1:0] dividend,
  input  logic [brc_pkg::DIV_W-1:0] divisor,
  output logic                      out_valid,
  output brc_pkg::item_t            out_item,
  output logic [brc_pkg::DIV_W-1:0] quotient
);

  logic [brc_pkg::DIV_W-1:0] rem [0:brc_pkg::DIV_W];
  logic [brc_pkg::DIV_W-1:0] num [0:brc_pkg::DIV_W];
  logic [brc_pkg::DIV_W-1:0] dsr [0:brc_pkg::DIV_W];
  brc_pkg::item_t            itm [0:brc_pkg::DIV_W];
  logic                      vld [0:brc_pkg::DIV_W];

  assign rem[0] = '0;
  assign num[0] = dividend;
  assign dsr[0] = divisor;
  assign itm[0] = in_item;
  assign vld[0] = in_valid;

  for (genvar k = 0; k < brc_pkg::DIV_W; k++) begin : g_stage
    logic [brc_pkg::DIV_W:0] sh;
    logic [brc_pkg::DIV_W:0] diff;
    assign sh   = {rem[k], num[k][brc_pkg::DIV_W-1]};
    assign diff = sh - {1'b0, dsr[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        // quotient bits shift in at the bottom of num as dividend bits leave
        if (!diff[brc_pkg::DIV_W]) begin
          rem[k+1] <= diff[brc_pkg::DIV_W-1:0];
          num[k+1] <= {num[k][brc_pkg::DIV_W-2:0], 1'b1};
        end else begin
          rem[k+1] <= sh[brc_pkg::DIV_W-1:0];
          num[k+1] <= {num[k][brc_pkg::DIV_W-2:0], 1'b0};
        end
        dsr[k+1] <= dsr[k];
        itm[k+1] <= itm[k];
      end
    end
  end

  assign out_valid = vld[brc_pkg::DIV_W];
  assign out_item  = itm[brc_pkg::DIV_W];
  assign quotient  = num[brc_pkg::DIV_W];

endmodule

FILE: rtl/core/barometer_raw_compensation_top.sv
// Depth: 18 stages plus two 32-stage dividers from accepted sample to result word.
// Throughput: one word per cycle; the whole pipe advances when the output register is free.
// A stall on the result side freezes every stage, so no word is lost or repeated.
// Reset (rst, synchronous): clears all valid bits and calibration registers to zero.
// Calibration is read directly by the stages; write it only while the pipe is empty.
module barometer_raw_compensation_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [brc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [brc_pkg::CFG_DW-1:0] cfg_data,
  brc_in_if.sink                     sample,
  brc_out_if.source                  result
);

  logic [47:0] a123;
  logic [47:0] a456;
  logic [31:0] b12;
  logic [31:0] mcmd;
  logic [1:0]  oss;

  always_ff @(posedge clk) begin
    if (rst) begin
      a123 <= '0;
      a456 <= '0;
      b12  <= '0;
      mcmd <= '0;
      oss  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        brc_pkg::CFG_A123: a123 <= cfg_data;
        brc_pkg::CFG_A456: a456 <= cfg_data;
        brc_pkg::CFG_B12:  b12  <= cfg_data[31:0];
        brc_pkg::CFG_MCMD: mcmd <= cfg_data[31:0];
        brc_pkg::CFG_OSS:  oss  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] ac1x4, ac2, ac3, b1, b2, mc, md, mc_abs;
  logic [31:0] ac4, ac5, ac6, b7_scale;

  assign ac1x4    = {{14{a123[15]}}, a123[15:0], 2'b00};
  assign ac2      = {{16{a123[31]}}, a123[31:16]};
  assign ac3      = {{16{a123[47]}}, a123[47:32]};
  assign ac4      = {16'b0, a456[15:0]};
  assign ac5      = {16'b0, a456[31:16]};
  assign ac6      = {16'b0, a456[47:32]};
  assign b1       = {{16{b12[15]}}, b12[15:0]};
  assign b2       = {{16{b12[31]}}, b12[31:16]};
  assign mc       = {{5{mcmd[15]}}, mcmd[15:0], 11'b0};
  assign md       = {{16{mcmd[31]}}, mcmd[31:16]};
  assign mc_abs   = mcmd[15] ? -mc : mc;
  assign b7_scale = 32'd50000 >> oss;

  brc_pkg::item_t st [0:brc_pkg::STAGES-1];
  brc_pkg::item_t nx [0:brc_pkg::STAGES-1];
  logic           v  [0:brc_pkg::STAGES-1];
  logic           nv [0:brc_pkg::STAGES-1];
  logic           adv;

  logic           d1_valid, d2_valid;
  brc_pkg::item_t d1_item, d2_item;
  logic [31:0]    d1_q, d2_q, d1_dsr, d2_dvd;

  assign adv          = !v[brc_pkg::STAGES-1] || result.ready;
  assign sample.ready = adv;

  assign d1_dsr = st[3].pb[31] ? -st[3].pb : st[3].pb;
  assign d2_dvd = st[12].pb[31] ? st[12].pb : {st[12].pb[30:0], 1'b0};

  brc_div u_div_t (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(v[3]), .in_item(st[3]),
    .dividend(mc_abs), .divisor(d1_dsr),
    .out_valid(d1_valid), .out_item(d1_item), .quotient(d1_q)
  );

  brc_div u_div_p (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(v[12]), .in_item(st[12]),
    .dividend(d2_dvd), .divisor(st[12].pc),
    .out_valid(d2_valid), .out_item(d2_item), .quotient(d2_q)
  );

  logic signed [31:0] tdiv, tt, b4, pq;

  always_comb begin
    for (int k = 1; k < brc_pkg::STAGES; k++) begin
      nx[k] = st[k-1];
      nv[k] = v[k-1];
    end
    nv[0] = sample.valid;
    nv[4] = d1_valid;
    nv[13] = d2_valid;

    nx[0]    = '0;
    nx[0].op = sample.operation;
    nx[0].pa = {16'b0, sample.raw_temperature};
    nx[0].up = 24'(sample.raw_pressure >> (4'd8 - {2'b00, oss}));

    nx[1].pa = 32'((st[0].pa - $signed(ac6)) * $signed(ac5));
    nx[2].x1 = st[1].pa >>> 15;

    tdiv      = st[2].x1 + md;
    nx[3].pb  = tdiv;
    nx[3].err = (tdiv == 32'sd0);
    nx[3].neg = mcmd[15] ^ tdiv[31];

    nx[4]    = d1_item;
    nx[4].b5 = d1_item.x1 + (d1_item.neg ? -$signed(d1_q) : $signed(d1_q));

    tt = (st[4].b5 + 32'sd8) >>> 4;
    nx[5].b6 = st[4].b5 - 32'sd4000;
    if (tt > 32'sd32767) begin
      nx[5].t = 16'sh7fff;
    end else if (tt < -32'sd32768) begin
      nx[5].t = 16'sh8000;
    end else begin
      nx[5].t = 16'(tt);
    end

    nx[6].pa = 32'(st[5].b6 * st[5].b6);
    nx[6].pb = 32'(ac2 * st[5].b6);
    nx[6].pc = 32'(ac3 * st[5].b6);

    nx[7].sq = st[6].pa >>> 12;
    nx[7].pb = st[6].pb >>> 11;
    nx[7].pc = st[6].pc >>> 13;

    nx[8].pa = 32'(b2 * st[7].sq);
    nx[8].p  = 32'(b1 * st[7].sq);

    nx[9].b3 = ac1x4 + (st[8].pa >>> 11) + st[8].pb;
    nx[9].x3 = (st[8].p >>> 16) + st[8].pc;

    nx[10].b3 = ((st[9].b3 <<< oss) + 32'sd2) >>> 2;
    nx[10].x3 = ((st[9].x3 + 32'sd2) >>> 2) + 32'sd32768;

    nx[11].pa = $signed(32'(ac4 * $unsigned(st[10].x3)));
    nx[11].pb = $signed(32'(({8'b0, st[10].up} - $unsigned(st[10].b3)) * b7_scale));

    b4 = $signed($unsigned(st[11].pa) >> 15);
    nx[12].pc = b4;
    if (st[11].op && b4 == 32'sd0) begin
      nx[12].err = 1'b1;
    end

    // large b7 is divided first and doubled after, as the datasheet does
    pq = d2_item.pb[31] ? $signed({d2_q[30:0], 1'b0}) : $signed(d2_q);
    nx[13]    = d2_item;
    nx[13].p  = pq;
    nx[13].pa = pq >>> 8;

    nx[14].pa = 32'(st[13].pa * st[13].pa);
    nx[14].pb = 32'(st[13].p * -32'sd7357);

    nx[15].pa = 32'(st[14].pa * 32'sd3038);

    nx[16].x3 = (st[15].pa >>> 16) + (st[15].pb >>> 16) + 32'sd3791;

    nx[17].p = st[16].p + (st[16].x3 >>> 4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < brc_pkg::STAGES; k++) begin
        v[k] <= 1'b0;
      end
    end else if (adv) begin
      for (int k = 0; k < brc_pkg::STAGES; k++) begin
        v[k] <= nv[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < brc_pkg::STAGES; k++) begin
        st[k] <= nx[k];
      end
    end
  end

  assign result.valid              = v[brc_pkg::STAGES-1];
  assign result.divide_error       = st[brc_pkg::STAGES-1].err;
  assign result.temperature_tenths = st[brc_pkg::STAGES-1].err ? 16'sd0
                                                               : st[brc_pkg::STAGES-1].t;
  assign result.pressure_pa        = (st[brc_pkg::STAGES-1].err || !st[brc_pkg::STAGES-1].op)
                                     ? 32'sd0 : st[brc_pkg::STAGES-1].p;

endmodule

FILE: verif/barometer_raw_compensation_top_tb.sv
// Self-checking bench for the barometer compensation pipeline with random stalls.
`timescale 1ns / 100ps

module barometer_raw_compensation_top_tb;

  localparam int LATENCY = 82;
  localparam int SETTLE  = LATENCY + 10;
  localparam int LIMIT   = 600000;

  typedef struct {
    logic signed [15:0] temp;
    logic signed [31:0] press;
    logic               err;
  } comp_word_t;

  class comp_scoreboard;
    logic [47:0] a123, a456;
    logic [31:0] b12, mcmd;
    logic [1:0]  oss;
    comp_word_t  pending[$];
    int          errors;
    int          checked;
    int          div_errs;

    function new();
      a123 = '0; a456 = '0; b12 = '0; mcmd = '0; oss = '0;
      errors = 0; checked = 0; div_errs = 0;
    endfunction

    function longint w32(longint v);
      return longint'(int'(v));
    endfunction

    // Compensates one sample with the current calibration and queues the word.
    function void note_sample(bit op, logic [15:0] ut, logic [23:0] rp);
      longint ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
      longint x1, x2, x3, b3, b5, b6, dv, t, p, sq;
      bit [31:0] ac4, up, b4, b7, q, tmp;
      bit err;
      comp_word_t e;
      ac1 = longint'($signed(a123[15:0]));
      ac2 = longint'($signed(a123[31:16]));
      ac3 = longint'($signed(a123[47:32]));
      ac4 = {16'd0, a456[15:0]};
      ac5 = longint'(a456[31:16]);
      ac6 = longint'(a456[47:32]);
      b1  = longint'($signed(b12[15:0]));
      b2  = longint'($signed(b12[31:16]));
      mc  = longint'($signed(mcmd[15:0]));
      md  = longint'($signed(mcmd[31:16]));
      up  = {8'd0, rp} >> (8 - oss);
      err = 0; t = 0; p = 0;
      x1 = w32((longint'(ut) - ac6) * ac5) >>> 15;
      dv = w32(x1 + md);
      if (dv == 0) begin
        err = 1;
      end else begin
        x2 = w32((mc * 2048) / dv);
        b5 = w32(x1 + x2);
        t  = w32(b5 + 8) >>> 4;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        if (op) begin
          b6 = w32(b5 - 4000);
          sq = w32(b6 * b6) >>> 12;
          x1 = w32(b2 * sq) >>> 11;
          x2 = w32(ac2 * b6) >>> 11;
          x3 = w32(x1 + x2);
          b3 = w32(ac1 * 4 + x3);
          b3 = w32(b3 * (longint'(1) << oss));
          b3 = w32(b3 + 2) >>> 2;
          x1 = w32(ac3 * b6) >>> 13;
          x2 = w32(b1 * sq) >>> 16;
          x3 = w32(w32(x1 + x2) + 2) >>> 2;
          tmp = 32'(w32(x3 + 32768));
          tmp = ac4 * tmp;
          b4  = tmp >> 15;
          tmp = 32'(b3);
          b7  = (up - tmp) * (32'd50000 >> oss);
          if (b4 == 0) begin
            err = 1;
          end else begin
            if (b7 < 32'h8000_0000) q = (b7 * 32'd2) / b4;
            else q = (b7 / b4) * 32'd2;
            p  = longint'($signed(q));
            x1 = p >>> 8;
            x1 = w32(x1 * x1);
            x1 = w32(x1 * 3038) >>> 16;
            x2 = w32(-7357 * p) >>> 16;
            x3 = w32(w32(x1 + x2) + 3791);
            p  = w32(p + (x3 >>> 4));
          end
        end
      end
      if (err) begin
        e.temp = '0; e.press = '0; e.err = 1;
      end else begin
        e.temp = 16'(t); e.press = 32'(p); e.err = 0;
      end
      pending.push_back(e);
    endfunction

    function void check_word(logic signed [15:0] temp, logic signed [31:0] press,
                             logic derr);
      comp_word_t e;
      checked++;
      if (derr) div_errs++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected word temp=%0d press=%0d err=%0b", $time, temp, press,
                 derr);
        return;
      end
      e = pending.pop_front();
      if (temp !== e.temp) begin
        errors++;
        $display("%0t: temperature_tenths expected %0d actual %0d", $time, e.temp, temp);
      end
      if (press !== e.press) begin
        errors++;
        $display("%0t: pressure_pa expected %0d actual %0d", $time, e.press, press);
      end
      if (derr !== e.err) begin
        errors++;
        $display("%0t: divide_error expected %0b actual %0b", $time, e.err, derr);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [brc_pkg::CFG_IW-1:0] cfg_index;
  logic [brc_pkg::CFG_DW-1:0] cfg_data;
  bit   quiet;
  int   stall_left;
  int   cycles;
  int   sent;

  brc_in_if  sample_ch ();
  brc_out_if result_ch ();

  comp_scoreboard sb = new();

  barometer_raw_compensation_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t: timeout, %0d words still pending", $time, sb.pending.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side backpressure in bursts.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 0;
      stall_left <= 0;
    end else if (quiet) begin
      result_ch.ready <= 1;
    end else if (stall_left > 0) begin
      result_ch.ready <= 0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      result_ch.ready <= 0;
      stall_left <= $urandom_range(1, 18) - 1;
    end else begin
      result_ch.ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_word(result_ch.temperature_tenths, result_ch.pressure_pa,
                    result_ch.divide_error);
  end

  task automatic send_sample(bit op, logic [15:0] ut, logic [23:0] rp);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      sample_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid           <= 1;
    sample_ch.operation       <= op;
    sample_ch.raw_temperature <= ut;
    sample_ch.raw_pressure    <= rp;
    do @(posedge clk); while (!sample_ch.ready);
    sb.note_sample(op, ut, rp);
    sent++;
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(brc_pkg::cfg_idx_t idx, logic [brc_pkg::CFG_DW-1:0] val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      brc_pkg::CFG_A123: sb.a123 = val[47:0];
      brc_pkg::CFG_A456: sb.a456 = val[47:0];
      brc_pkg::CFG_B12:  sb.b12  = val[31:0];
      brc_pkg::CFG_MCMD: sb.mcmd = val[31:0];
      brc_pkg::CFG_OSS:  sb.oss  = val[1:0];
      default: ;
    endcase
  endtask

  // Pipe must be empty before calibration changes.
  task automatic drain();
    sample_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_cal(logic [47:0] a1, logic [47:0] a4, logic [31:0] b,
                          logic [31:0] m, logic [1:0] os);
    drain();
    write_reg(brc_pkg::CFG_A123, a1);
    write_reg(brc_pkg::CFG_A456, a4);
    write_reg(brc_pkg::CFG_B12, {16'd0, b});
    write_reg(brc_pkg::CFG_MCMD, {16'd0, m});
    write_reg(brc_pkg::CFG_OSS, {46'd0, os});
    cfg_we <= 0;
  endtask

  // Typical factory words with small random perturbation.
  task automatic load_typical(logic [1:0] os);
    logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    ac1 = 16'(408 + $urandom_range(0, 200) - 100);
    ac2 = 16'(-72 + $urandom_range(0, 40) - 20);
    ac3 = 16'(-14383 + $urandom_range(0, 400) - 200);
    ac4 = 16'(32741 + $urandom_range(0, 400) - 200);
    ac5 = 16'(32757 + $urandom_range(0, 400) - 200);
    ac6 = 16'(23153 + $urandom_range(0, 400) - 200);
    b1  = 16'(6190 + $urandom_range(0, 200) - 100);
    b2  = 16'(4 + $urandom_range(0, 8));
    mc  = 16'(-8711 + $urandom_range(0, 400) - 200);
    md  = 16'(2868 + $urandom_range(0, 200) - 100);
    load_cal({ac3, ac2, ac1}, {ac6, ac5, ac4}, {b2, b1}, {md, mc}, os);
  endtask

  task automatic random_burst(int n, bit realistic);
    logic [15:0] ut;
    logic [23:0] rp;
    repeat (n) begin
      if (realistic && $urandom_range(0, 3) != 0) begin
        ut = 16'($urandom_range(20000, 35000));
        rp = 24'($urandom_range(5000000, 11000000));
      end else begin
        ut = 16'($urandom);
        rp = 24'($urandom);
      end
      send_sample(1'($urandom_range(0, 1)), ut, rp);
    end
  endtask

  initial begin
    rst = 1;
    quiet = 0;
    cycles = 0;
    sent = 0;
    cfg_we <= 0;
    cfg_index <= brc_pkg::CFG_A123;
    cfg_data <= '0;
    sample_ch.valid <= 0;
    sample_ch.operation <= 0;
    sample_ch.raw_temperature <= '0;
    sample_ch.raw_pressure <= '0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Reset calibration: temperature divisor is zero.
    send_sample(0, 16'd27898, 24'd0);
    send_sample(1, 16'hFFFF, 24'hFFFFFF);

    // Datasheet-style words; extremes of the raw fields and both operations.
    load_cal({16'hC7D1, 16'hFFB8, 16'd408}, {16'd23153, 16'd32757, 16'd32741},
             {16'd4, 16'd6190}, {16'd2868, 16'hDDF9}, 2'd0);
    send_sample(0, 16'd27898, 24'd0);
    send_sample(1, 16'd27898, 24'd23843 << 8);
    send_sample(1, 16'd0, 24'd0);
    send_sample(1, 16'hFFFF, 24'hFFFFFF);
    send_sample(0, 16'hFFFF, 24'hFFFFFF);
    send_sample(1, 16'd0, 24'hFFFFFF);
    send_sample(1, 16'hFFFF, 24'd0);
    send_sample(1, 16'h8000, 24'h800000);

    // Zero AC4: pressure divisor is zero.
    load_cal({16'hC7D1, 16'hFFB8, 16'd408}, {16'd23153, 16'd32757, 16'd0},
             {16'd4, 16'd6190}, {16'd2868, 16'hDDF9}, 2'd3);
    send_sample(1, 16'd27898, 24'h5D2300);
    send_sample(0, 16'd27898, 24'h5D2300);

    // AC5 zero and MD=0: temperature divisor is zero in both operations.
    load_cal(48'h1234_5678_9ABC, {16'd100, 16'd0, 16'd500}, 32'h0004_1830, 32'h0000_DDF9, 2'd1);
    send_sample(1, 16'd30000, 24'h123456);
    send_sample(0, 16'd1, 24'h000001);

    // All ones in every calibration word.
    load_cal(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
    send_sample(1, 16'hFFFF, 24'hFFFFFF);
    send_sample(1, 16'd0, 24'd0);
    send_sample(0, 16'h5555, 24'hAAAAAA);
    send_sample(1, 16'hAAAA, 24'h555555);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 3 == 2)
        load_cal(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), $urandom, $urandom,
                 2'(ph));
      else
        load_typical(2'(ph));
      if (ph == 7) quiet = 1;
      random_burst(100, ph % 3 != 2);
    end

    sample_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d samples over thirteen calibration sets, all oversampling settings;",
             sent);
    $display("checked %0d result words, %0d with divide error.", sb.checked, sb.div_errs);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
